>>> src/tqks_pkg.sv
// Shared types, constants and byte-class functions for the trailing qualifier keyword scanner.
`default_nettype none
package tqks_pkg;

    localparam int MAX_SPAN_DEF = 4096;
    localparam int OFF_W        = 13;
    localparam int S_DATA_W     = 8;
    localparam int M_DATA_W     = 32;
    localparam int KW_LEN       = 8;

    typedef enum logic [2:0] {
        M_NORMAL,
        M_IDENT,
        M_SLASH,
        M_LINE,
        M_BLOCK,
        M_BLOCK_STAR,
        M_QUOTE,
        M_QUOTE_ESC
    } mode_t;

    typedef enum logic [1:0] {
        PC_START,
        PC_SPACE_COLON,
        PC_OTHER
    } pclass_t;

    typedef struct packed {
        mode_t      mode;
        logic       quote_dbl;
        logic       id_valid;
        logic [3:0] id_len;
        logic       match_req;
        logic       match_opt;
        logic       prefix_ok;
        pclass_t    prev_class;
        logic       ws_ext;
        logic       over;
    } ctrl_t;

    typedef struct packed {
        logic set_begin;
        logic set_ext;
        logic hit;
    } upd_t;

    localparam ctrl_t CTRL_RESET = '{
        mode:       M_NORMAL,
        quote_dbl:  1'b0,
        id_valid:   1'b0,
        id_len:     4'd0,
        match_req:  1'b0,
        match_opt:  1'b0,
        prefix_ok:  1'b0,
        prev_class: PC_START,
        ws_ext:     1'b0,
        over:       1'b0
    };

    localparam logic [7:0] KW_REQ [KW_LEN] = '{"r", "e", "q", "u", "i", "r", "e", "d"};
    localparam logic [7:0] KW_OPT [KW_LEN] = '{"o", "p", "t", "i", "o", "n", "a", "l"};

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic logic is_id_start(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
    endfunction

    function automatic logic is_id_char(input logic [7:0] b);
        return is_id_start(b) || ((b >= "0") && (b <= "9"));
    endfunction

endpackage
`default_nettype wire

>>> src/trailing_qualifier_keyword_scanner.sv
// Top level of the trailing qualifier keyword scanner: scan state, offsets and result register.
`default_nettype none
// Takes one source byte per cycle and updates the whole scan state in that same cycle. The
// result word for a span appears on the master side in the cycle after its last byte is taken
// and is held in a single output register; the slave side keeps taking bytes every cycle
// except when that register is still full and not being drained.
// Offsets count from zero at the first byte and saturate at MAX_SPAN, which also sets overflow.
module trailing_qualifier_keyword_scanner #(
    parameter int MAX_SPAN = tqks_pkg::MAX_SPAN_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [tqks_pkg::S_DATA_W-1:0] s_tdata,  // [7:0] char_byte
    input  wire                          s_tlast,  // span_last
    input  wire                          s_tuser,  // span_first
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [tqks_pkg::M_DATA_W-1:0] m_tdata  // [0] found, [13:1] qual_start,
                                                   // [26:14] qual_stop, [27] overflow
);
    import tqks_pkg::*;

    localparam int POS_W = $clog2(MAX_SPAN + 1);
    localparam int EXT_W = (POS_W > OFF_W) ? POS_W : OFF_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SPAN);

    ctrl_t             ctrl_reg, ctrl_next, ctrl_cur, ctrl_step;
    upd_t              upd;
    logic [POS_W-1:0]  pos_reg, pos_next, pos_cur, pos_end;
    logic [POS_W-1:0]  beg_reg, beg_next, beg_cur, beg_upd;
    logic [POS_W-1:0]  ext_reg, ext_next, ext_cur, ext_upd;
    logic              at_max;
    logic              accept;
    logic              out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic [EXT_W-1:0]  start_wide, stop_wide;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign ctrl_cur = s_tuser ? CTRL_RESET : ctrl_reg;
    assign pos_cur  = s_tuser ? '0 : pos_reg;
    assign beg_cur  = s_tuser ? '0 : beg_reg;
    assign ext_cur  = s_tuser ? '0 : ext_reg;
    assign at_max   = (pos_cur == POS_MAX);
    assign pos_end  = at_max ? POS_MAX : pos_cur + POS_W'(1);

    tqks_step u_step (
        .cur       (ctrl_cur),
        .char_byte (s_tdata[7:0]),
        .last      (s_tlast),
        .at_max    (at_max),
        .nxt       (ctrl_step),
        .upd       (upd)
    );

    assign beg_upd = upd.set_begin ? pos_cur : beg_cur;
    assign ext_upd = upd.set_ext ? pos_end : ext_cur;

    assign start_wide = EXT_W'(beg_upd);
    assign stop_wide  = EXT_W'(ext_upd);

    always_comb begin
        ctrl_next      = ctrl_reg;
        pos_next       = pos_reg;
        beg_next       = beg_reg;
        ext_next       = ext_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (accept) begin
            if (s_tlast) begin
                ctrl_next      = CTRL_RESET;
                pos_next       = '0;
                beg_next       = '0;
                ext_next       = '0;
                out_valid_next = 1'b1;
                out_data_next  = '0;
                out_data_next[0]            = upd.hit;
                out_data_next[OFF_W:1]      = upd.hit ? start_wide[OFF_W-1:0] : '0;
                out_data_next[2*OFF_W:OFF_W+1] = upd.hit ? stop_wide[OFF_W-1:0] : '0;
                out_data_next[2*OFF_W+1]    = ctrl_step.over;
            end else begin
                ctrl_next = ctrl_step;
                pos_next  = pos_end;
                beg_next  = beg_upd;
                ext_next  = ext_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg      <= CTRL_RESET;
            pos_reg       <= '0;
            beg_reg       <= '0;
            ext_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            ctrl_reg      <= ctrl_next;
            pos_reg       <= pos_next;
            beg_reg       <= beg_next;
            ext_reg       <= ext_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

>>> src/tqks_step.sv
// Next scan state for one byte: mode walk, identifier tracking and keyword match.
`default_nettype none
module tqks_step (
    input  var tqks_pkg::ctrl_t cur,
    input  wire [7:0]           char_byte,
    input  wire                 last,
    input  wire                 at_max,
    output tqks_pkg::ctrl_t     nxt,
    output tqks_pkg::upd_t      upd
);
    import tqks_pkg::*;

    always_comb begin
        ctrl_t      nx;
        upd_t       u;
        logic       do_norm;
        logic       ended;
        logic [7:0] qchar;

        nx      = cur;
        u       = '0;
        do_norm = 1'b0;
        ended   = 1'b0;
        qchar   = cur.quote_dbl ? 8'h22 : 8'h27;
        nx.over = cur.over | at_max;

        unique case (cur.mode)
            M_IDENT: begin
                if (is_id_char(char_byte)) begin
                    if (cur.id_len < 4'(KW_LEN)) begin
                        nx.match_req = cur.match_req && (char_byte == KW_REQ[cur.id_len[2:0]]);
                        nx.match_opt = cur.match_opt && (char_byte == KW_OPT[cur.id_len[2:0]]);
                    end else begin
                        nx.match_req = 1'b0;
                        nx.match_opt = 1'b0;
                    end
                    if (cur.id_len != 4'd15) begin
                        nx.id_len = cur.id_len + 4'd1;
                    end
                    u.set_ext = 1'b1;
                end else begin
                    nx.mode   = M_NORMAL;
                    nx.ws_ext = 1'b1;
                    ended     = 1'b1;
                    do_norm   = 1'b1;
                end
            end
            M_SLASH: begin
                if (char_byte == "/") begin
                    nx.mode = M_LINE;
                end else if (char_byte == "*") begin
                    nx.mode = M_BLOCK;
                end else begin
                    nx.id_valid = 1'b0;
                    nx.mode     = M_NORMAL;
                    do_norm     = 1'b1;
                end
            end
            M_LINE: begin
                if (char_byte == 8'h0a) begin
                    nx.mode = M_NORMAL;
                end
            end
            M_BLOCK: begin
                if (char_byte == "*") begin
                    nx.mode = M_BLOCK_STAR;
                end
            end
            M_BLOCK_STAR: begin
                if (char_byte == "/") begin
                    nx.mode = M_NORMAL;
                end else if (char_byte != "*") begin
                    nx.mode = M_BLOCK;
                end
            end
            M_QUOTE: begin
                if (char_byte == 8'h5c) begin
                    nx.mode = M_QUOTE_ESC;
                end else if (char_byte == qchar) begin
                    nx.mode = M_NORMAL;
                end
            end
            M_QUOTE_ESC: begin
                nx.mode = M_QUOTE;
            end
            M_NORMAL: begin
                do_norm = 1'b1;
            end
            default: begin
                nx.mode = M_NORMAL;
                do_norm = 1'b1;
            end
        endcase

        if (do_norm && !is_ws(char_byte)) begin
            if ((char_byte == "/") && !last) begin
                nx.mode = M_SLASH;
            end else if ((char_byte == 8'h22) || (char_byte == 8'h27)) begin
                nx.id_valid  = 1'b0;
                nx.quote_dbl = (char_byte == 8'h22);
                nx.mode      = M_QUOTE;
            end else if (is_id_start(char_byte)) begin
                nx.id_valid  = 1'b1;
                u.set_begin  = 1'b1;
                u.set_ext    = 1'b1;
                nx.ws_ext    = 1'b0;
                nx.id_len    = 4'd1;
                nx.match_req = (char_byte == KW_REQ[0]);
                nx.match_opt = (char_byte == KW_OPT[0]);
                nx.prefix_ok = (cur.prev_class != PC_OTHER);
                nx.mode      = M_IDENT;
            end else begin
                nx.id_valid = 1'b0;
            end
        end

        // extend the stop offset over whitespace after the identifier
        if (nx.ws_ext && (ended || (nx.mode != M_IDENT))) begin
            if (is_ws(char_byte)) begin
                u.set_ext = 1'b1;
            end else begin
                nx.ws_ext = 1'b0;
            end
        end

        nx.prev_class = (is_ws(char_byte) || (char_byte == ":")) ? PC_SPACE_COLON : PC_OTHER;

        u.hit = nx.id_valid && (nx.id_len == 4'(KW_LEN)) &&
                (nx.match_req || nx.match_opt) && nx.prefix_ok;

        nxt = nx;
        upd = u;
    end

endmodule
`default_nettype wire
